@@ src/slot_state_ring_buffer_core_assert.svh @@
// Assertion macros for the slot state ring buffer.
// Every macro samples on clk and is held off while arst_n is low.
`ifndef SLOT_STATE_RING_BUFFER_CORE_ASSERT_SVH
`define SLOT_STATE_RING_BUFFER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSRB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ssrb_pkg.sv @@
// Shared types and constants for the slot state ring buffer.
// Used by the controller, the datapath and the top level; no dependencies.
package ssrb_pkg;

	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int DATA_W  = 64;
	localparam int CNT_W   = 32;
	localparam int EMPTY_W = 5;

	// Operation codes; codes above OP_RD_DONE do nothing
	typedef enum logic [OP_W-1:0] {
		OP_WR_BEGIN  = 3'd0,
		OP_WR_COMMIT = 3'd1,
		OP_WR_ABORT  = 3'd2,
		OP_RD_BEGIN  = 3'd3,
		OP_RD_DONE   = 3'd4
	} op_t;

	// Per-slot phase
	typedef enum logic [1:0] {
		PH_EMPTY   = 2'd0,
		PH_WRITING = 2'd1,
		PH_READY   = 2'd2,
		PH_READING = 2'd3
	} phase_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_step; // write one empty phase during the clearing pass
		logic capture;    // take an input beat and read its slot
		logic exec;       // apply the op and load the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last; // clearing pass is at the last slot
		logic out_free;   // output register can take a result this cycle
	} sts_t;

	// Counter that sticks at all ones
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

@@ src/ssrb_ctrl.sv @@
// Controller state machine for the slot state ring buffer.
// Depends on ssrb_pkg; drives the datapath by cmd_t, watches sts_t.
module ssrb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ssrb_pkg::sts_t   sts,
	output ssrb_pkg::cmd_t   cmd
);
	import ssrb_pkg::*;

	ctrl_state_t state_q, state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait here while an older result is still unread
				if (sts.out_free) begin
					cmd.exec   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

endmodule

@@ src/ssrb_dp.sv @@
// Datapath for the slot state ring buffer: slot memories, pointers,
// counters and the output register. Depends on ssrb_pkg; run by ssrb_ctrl.
module ssrb_dp #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssrb_pkg::cmd_t                cmd,
	output ssrb_pkg::sts_t                sts,
	input  logic [ssrb_pkg::OP_W-1:0]     op,
	input  logic [ssrb_pkg::IDX_W-1:0]    slot_index,
	input  logic [ssrb_pkg::DATA_W-1:0]   frame_handle,
	input  logic [ssrb_pkg::DATA_W-1:0]   time_stamp,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [ssrb_pkg::IDX_W-1:0]    granted_slot,
	output logic [ssrb_pkg::DATA_W-1:0]   out_frame,
	output logic [ssrb_pkg::DATA_W-1:0]   out_time,
	output logic [ssrb_pkg::EMPTY_W-1:0]  empty_count,
	output logic [ssrb_pkg::CNT_W-1:0]    written_count,
	output logic [ssrb_pkg::CNT_W-1:0]    read_count,
	output logic [ssrb_pkg::CNT_W-1:0]    write_fail_count,
	output logic [ssrb_pkg::CNT_W-1:0]    read_fail_count
);
	import ssrb_pkg::*;

	localparam int PTR_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ECNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int IXW     = (PTR_W > IDX_W) ? PTR_W : IDX_W;
	localparam int EXW     = (ECNT_W > EMPTY_W) ? ECNT_W : EMPTY_W;
	localparam logic [PTR_W-1:0] PtrLast = PTR_W'(SLOT_COUNT - 1);

	// Slot memories
	phase_t              phase_mem [SLOT_COUNT];
	logic [DATA_W-1:0]   frame_mem [SLOT_COUNT];
	logic [DATA_W-1:0]   time_mem  [SLOT_COUNT];

	// Control state
	logic [PTR_W-1:0]    wp_q, rp_q, clr_q;
	logic [ECNT_W-1:0]   empty_q;
	logic [CNT_W-1:0]    commits_q, reads_q, wr_fail_q, rd_fail_q;
	logic                out_valid_q;

	// Captured beat and slot read data
	logic [OP_W-1:0]     op_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                idx_ok_s1;
	logic [PTR_W-1:0]    addr_s1;
	logic [DATA_W-1:0]   frame_s1, time_s1;
	phase_t              phase_s1;
	logic [DATA_W-1:0]   frame_rd_s1, time_rd_s1;

	// Output register payload
	logic                ok_q;
	logic [IDX_W-1:0]    granted_q;
	logic [DATA_W-1:0]   frame_out_q, time_out_q;
	logic [EMPTY_W-1:0]  empty_out_q;

	// Capture-side address and range check
	logic [IXW-1:0]      idx_ext;
	logic [PTR_W-1:0]    cap_addr;
	logic                idx_ok;

	// Execute-side results
	logic                ph_we, data_we, ok_n;
	phase_t              ph_wdata;
	logic [PTR_W-1:0]    wp_n, rp_n;
	logic [ECNT_W-1:0]   empty_n;
	logic [CNT_W-1:0]    commits_n, reads_n, wr_fail_n, rd_fail_n;
	logic [DATA_W-1:0]   frame_o_n, time_o_n;
	logic [IDX_W-1:0]    granted_n;
	logic [IXW-1:0]      addr_ext;
	logic [EXW-1:0]      empty_ext;

	assign idx_ext   = IXW'(slot_index);
	assign idx_ok    = (32'(slot_index) < SLOT_COUNT);
	assign addr_ext  = IXW'(addr_s1);
	assign empty_ext = EXW'(empty_n);

	// Slot addressed by the incoming op
	always_comb begin
		case (op)
			OP_WR_BEGIN: cap_addr = wp_q;
			OP_RD_BEGIN: cap_addr = rp_q;
			default:     cap_addr = idx_ext[PTR_W-1:0];
		endcase
	end

	// Capture the beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1     <= op;
			idx_s1    <= slot_index;
			idx_ok_s1 <= idx_ok;
			addr_s1   <= cap_addr;
			frame_s1  <= frame_handle;
			time_s1   <= time_stamp;
		end
	end

	// Phase memory: registered read on capture, write on clear or execute
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			phase_s1 <= phase_mem[cap_addr];
		end
		if (cmd.clear_step) begin
			phase_mem[clr_q] <= PH_EMPTY;
		end else if (ph_we) begin
			phase_mem[addr_s1] <= ph_wdata;
		end
	end

	// Frame and timestamp memories; a ready slot always holds committed data
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_rd_s1 <= frame_mem[cap_addr];
			time_rd_s1  <= time_mem[cap_addr];
		end
		if (data_we) begin
			frame_mem[addr_s1] <= frame_s1;
			time_mem[addr_s1]  <= time_s1;
		end
	end

	// Apply the captured op
	always_comb begin
		ph_we     = 1'b0;
		data_we   = 1'b0;
		ph_wdata  = PH_EMPTY;
		ok_n      = 1'b1;
		granted_n = idx_s1;
		frame_o_n = '0;
		time_o_n  = '0;
		wp_n      = wp_q;
		rp_n      = rp_q;
		empty_n   = empty_q;
		commits_n = commits_q;
		reads_n   = reads_q;
		wr_fail_n = wr_fail_q;
		rd_fail_n = rd_fail_q;
		case (op_s1)
			OP_WR_BEGIN: begin
				granted_n = addr_ext[IDX_W-1:0];
				if (phase_s1 == PH_EMPTY) begin
					ph_we    = 1'b1;
					ph_wdata = PH_WRITING;
					empty_n  = empty_q - 1'b1;
					wp_n     = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
				end else begin
					ok_n      = 1'b0;
					wr_fail_n = sat_inc(wr_fail_q);
				end
			end
			OP_WR_COMMIT: begin
				if (idx_ok_s1) begin
					ph_we     = 1'b1;
					data_we   = 1'b1;
					ph_wdata  = PH_READY;
					commits_n = sat_inc(commits_q);
					if (phase_s1 == PH_EMPTY) begin
						empty_n = empty_q - 1'b1;
					end
				end
			end
			OP_WR_ABORT, OP_RD_DONE: begin
				if (idx_ok_s1) begin
					ph_we    = 1'b1;
					ph_wdata = PH_EMPTY;
					if (phase_s1 != PH_EMPTY) begin
						empty_n = empty_q + 1'b1;
					end
				end
			end
			OP_RD_BEGIN: begin
				granted_n = addr_ext[IDX_W-1:0];
				if (phase_s1 == PH_READY) begin
					ph_we     = 1'b1;
					ph_wdata  = PH_READING;
					frame_o_n = frame_rd_s1;
					time_o_n  = time_rd_s1;
					reads_n   = sat_inc(reads_q);
					rp_n      = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
				end else begin
					ok_n      = 1'b0;
					rd_fail_n = sat_inc(rd_fail_q);
				end
			end
			default: begin
			end
		endcase
		if (!cmd.exec) begin
			ph_we   = 1'b0;
			data_we = 1'b0;
		end
	end

	// Pointers, counters, clearing counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			clr_q       <= '0;
			empty_q     <= ECNT_W'(SLOT_COUNT);
			commits_q   <= '0;
			reads_q     <= '0;
			wr_fail_q   <= '0;
			rd_fail_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= (clr_q == PtrLast) ? '0 : clr_q + 1'b1;
			end
			if (cmd.exec) begin
				wp_q      <= wp_n;
				rp_q      <= rp_n;
				empty_q   <= empty_n;
				commits_q <= commits_n;
				reads_q   <= reads_n;
				wr_fail_q <= wr_fail_n;
				rd_fail_q <= rd_fail_n;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q        <= ok_n;
			granted_q   <= granted_n;
			frame_out_q <= frame_o_n;
			time_out_q  <= time_o_n;
			empty_out_q <= empty_ext[EMPTY_W-1:0];
		end
	end

	assign sts = '{clear_last: (clr_q == PtrLast), out_free: (!out_valid_q || out_ready)};

	assign out_valid        = out_valid_q;
	assign ok               = ok_q;
	assign granted_slot     = granted_q;
	assign out_frame        = frame_out_q;
	assign out_time         = time_out_q;
	assign empty_count      = empty_out_q;
	assign written_count    = commits_q;
	assign read_count       = reads_q;
	assign write_fail_count = wr_fail_q;
	assign read_fail_count  = rd_fail_q;

endmodule

@@ src/slot_state_ring_buffer_core.sv @@
// Top level of the slot state ring buffer: controller plus datapath.
// Depends on ssrb_pkg, ssrb_ctrl, ssrb_dp and the assertion macro header.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_ready | op, slot_index, frame_handle, time_stamp
//   output  | out_valid/out_ready | ok, granted_slot, out_frame, out_time,
//           |                     | empty_count, written_count, read_count,
//           |                     | write_fail_count, read_fail_count
//
// A beat is taken in idle, and its slot's phase and data are read from memory
// into registers; in execute the op is applied and the result lands in the
// output register. No new beat is taken until the last one has executed.
// After reset a clearing pass empties the phase memory with in_ready low.
// A result still waiting in the output register holds the next beat in
// execute until out_ready frees the register.
`include "slot_state_ring_buffer_core_assert.svh"

module slot_state_ring_buffer_core #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ssrb_pkg::OP_W-1:0]     op,
	input  logic [ssrb_pkg::IDX_W-1:0]    slot_index,
	input  logic [ssrb_pkg::DATA_W-1:0]   frame_handle,
	input  logic [ssrb_pkg::DATA_W-1:0]   time_stamp,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [ssrb_pkg::IDX_W-1:0]    granted_slot,
	output logic [ssrb_pkg::DATA_W-1:0]   out_frame,
	output logic [ssrb_pkg::DATA_W-1:0]   out_time,
	output logic [ssrb_pkg::EMPTY_W-1:0]  empty_count,
	output logic [ssrb_pkg::CNT_W-1:0]    written_count,
	output logic [ssrb_pkg::CNT_W-1:0]    read_count,
	output logic [ssrb_pkg::CNT_W-1:0]    write_fail_count,
	output logic [ssrb_pkg::CNT_W-1:0]    read_fail_count
);
	import ssrb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ssrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssrb_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.op               (op),
		.slot_index       (slot_index),
		.frame_handle     (frame_handle),
		.time_stamp       (time_stamp),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.ok               (ok),
		.granted_slot     (granted_slot),
		.out_frame        (out_frame),
		.out_time         (out_time),
		.empty_count      (empty_count),
		.written_count    (written_count),
		.read_count       (read_count),
		.write_fail_count (write_fail_count),
		.read_fail_count  (read_fail_count)
	);

	// Only one op in flight between capture and execute
	`SSRB_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "beat taken while busy")

	// A refused begin never carries slot data
	`SSRB_ASSERT_SAME(a_refused_no_data, out_valid && !ok, out_frame == '0 && out_time == '0, "refused op returned data")

	// A new result only appears after an execute step
	`SSRB_ASSERT_SAME(a_result_from_exec, $rose(out_valid), $past(cmd.exec), "result without execute")

	// No execute while the clearing pass runs
	`SSRB_ASSERT_SAME(a_no_exec_in_clear, cmd.clear_step, !cmd.exec && !cmd.capture, "op during clearing pass")

endmodule
